### sv/btmc_pkg.sv
// ---------------------------------------------------------------------------
// Balance tilt motor controller package
// Shared types, command structs, register codes and scaling constants.
// ---------------------------------------------------------------------------
package btmc_pkg;

   // Field widths
   localparam int SampleW = 12;
   localparam int TermW   = 16;
   localparam int DutyW   = 14;
   localparam int AngleW  = 32;

   // Datapath widths
   localparam int DiffW   = 13;   // offset minus sample
   localparam int RateW   = 27;   // rate and tilt in Q16 degrees
   localparam int MulAW   = 33;   // signed multiplier operand A
   localparam int MulBW   = 17;   // signed multiplier operand B (unsigned gains)
   localparam int ProdW   = 50;
   localparam int SumW    = 43;   // rate plus correction
   localparam int SumLoW  = 21;   // low slice of the split step multiply
   localparam int AccW    = 60;
   localparam int WideW   = 46;   // integral update and wheel sums
   localparam int WheelW  = 15;   // saturated wheel command

   // Scaling constants
   localparam logic signed [MulBW-1:0]  RateScale = 17'sd13107;  // 0.2 in Q16
   localparam logic signed [MulBW-1:0]  TiltScale = 17'sd8520;   // 0.13 in Q16
   localparam logic [DutyW-1:0]         DutyFull  = 14'd10000;
   localparam logic signed [WideW-1:0]  DutyLimit = 46'sd9900;
   localparam logic signed [AngleW-1:0] HaltHigh  = 32'sd2162688;  // 33 degrees
   localparam logic signed [AngleW-1:0] HaltLow   = -32'sd720896;  // -11 degrees

   // Register reset values
   localparam logic [11:0] GyroBiasReset   = 12'd2048;
   localparam logic [11:0] AccelZeroReset  = 12'd1257;
   localparam logic [15:0] AngleGainReset  = 16'd1370;
   localparam logic [9:0]  RateGainReset   = 10'd22;
   localparam logic [15:0] StepTimeReset   = 16'd328;
   localparam logic [15:0] InvTcReset      = 16'd256;

   // Register indexes
   typedef enum logic [2:0] {
      CSR_GYRO_BIAS,
      CSR_ACCEL_ZERO,
      CSR_ANGLE_GAIN,
      CSR_RATE_GAIN,
      CSR_DEAD_LEFT,
      CSR_DEAD_RIGHT,
      CSR_STEP_TIME,
      CSR_INV_TIME_CONSTANT
   } csr_index_type;

   typedef struct packed {
      logic [11:0] gyro_bias;
      logic [11:0] accel_zero;
      logic [15:0] angle_gain;
      logic [9:0]  rate_gain;
      logic [11:0] dead_left;
      logic [11:0] dead_right;
      logic [15:0] step_time_q16;
      logic [15:0] inv_time_constant_q8;
   } cfg_type;

   // Operand selection for the shared multiplier
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_RATE,
      MUL_TILT,
      MUL_CORR,
      MUL_STEP_LO,
      MUL_STEP_HI,
      MUL_PD_ANGLE,
      MUL_PD_RATE
   } mul_op_type;

   // What the datapath captures from the product register
   typedef enum logic [3:0] {
      CAP_NONE,
      CAP_RATE,
      CAP_TILT,
      CAP_SUM,
      CAP_ACC_SET,
      CAP_ACC_HI,
      CAP_NEXT,
      CAP_ACC_ADD,
      CAP_WHEEL
   } cap_op_type;

   typedef struct packed {
      logic       load;
      mul_op_type mul_op;
      cap_op_type cap_op;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic halt;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [DutyW-1:0] a;
      logic [DutyW-1:0] b;
   } duty_pair_type;

   // Map a saturated wheel command onto one H-bridge pair.
   // A command of zero counts as forward.
   function automatic duty_pair_type bridge(input logic signed [WheelW-1:0] cmd,
                                            input logic [11:0] dead);
      logic signed [WheelW-1:0] mag;
      logic signed [TermW-1:0]  low;
      logic [DutyW-1:0]         low_duty;
      duty_pair_type            pair;
      mag      = cmd[WheelW-1] ? -cmd : cmd;
      low      = $signed({2'b00, DutyFull}) - TermW'(mag) - $signed({4'b0000, dead});
      low_duty = low[TermW-1] ? '0 : low[DutyW-1:0];
      if (cmd[WheelW-1]) begin
         pair.a = low_duty;
         pair.b = DutyFull;
      end else begin
         pair.a = DutyFull;
         pair.b = low_duty;
      end
      return pair;
   endfunction

endpackage

### sv/btmc_regs.sv
// ---------------------------------------------------------------------------
// Balance tilt motor controller register file
// Holds the eight configuration registers written through the CSR channel.
// ---------------------------------------------------------------------------
module btmc_regs (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output btmc_pkg::cfg_type  cfg
);

   btmc_pkg::cfg_type cfg_ff;
   btmc_pkg::cfg_type cfg_in;

   // Writes complete in a single beat.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index and keep only the register's width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (btmc_pkg::csr_index_type'(csr_index))
            btmc_pkg::CSR_GYRO_BIAS:         cfg_in.gyro_bias            = csr_data[11:0];
            btmc_pkg::CSR_ACCEL_ZERO:        cfg_in.accel_zero           = csr_data[11:0];
            btmc_pkg::CSR_ANGLE_GAIN:        cfg_in.angle_gain           = csr_data;
            btmc_pkg::CSR_RATE_GAIN:         cfg_in.rate_gain            = csr_data[9:0];
            btmc_pkg::CSR_DEAD_LEFT:         cfg_in.dead_left            = csr_data[11:0];
            btmc_pkg::CSR_DEAD_RIGHT:        cfg_in.dead_right           = csr_data[11:0];
            btmc_pkg::CSR_STEP_TIME:         cfg_in.step_time_q16        = csr_data;
            btmc_pkg::CSR_INV_TIME_CONSTANT: cfg_in.inv_time_constant_q8 = csr_data;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gyro_bias            <= btmc_pkg::GyroBiasReset;
         cfg_ff.accel_zero           <= btmc_pkg::AccelZeroReset;
         cfg_ff.angle_gain           <= btmc_pkg::AngleGainReset;
         cfg_ff.rate_gain            <= btmc_pkg::RateGainReset;
         cfg_ff.dead_left            <= '0;
         cfg_ff.dead_right           <= '0;
         cfg_ff.step_time_q16        <= btmc_pkg::StepTimeReset;
         cfg_ff.inv_time_constant_q8 <= btmc_pkg::InvTcReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/btmc_ctrl.sv
// ---------------------------------------------------------------------------
// Balance tilt motor controller sequencer
// Steps the datapath through one control tick with a fixed command schedule.
// ---------------------------------------------------------------------------
module btmc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  btmc_pkg::status_type  status,
   output btmc_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      STEP_RATE,
      STEP_TILT,
      STEP_TILT_CAP,
      STEP_CORR,
      STEP_SUM,
      STEP_LO,
      STEP_HI,
      STEP_PD_ANGLE,
      STEP_PD_RATE,
      STEP_PD_ADD,
      STEP_WHEEL
   } step_type;

   state_type state_ff;
   state_type state_in;
   step_type  step_ff;
   step_type  step_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Command decode: at most one multiplier issue and one capture per step.
   always_comb begin
      cmd        = '0;
      cmd.load   = accept;
      cmd.finish = (state_ff == ST_DONE) && status.out_free;
      if (state_ff == ST_BUSY) begin
         case (step_ff)
            STEP_RATE:     cmd.mul_op = btmc_pkg::MUL_RATE;
            STEP_TILT: begin
               cmd.mul_op = btmc_pkg::MUL_TILT;
               cmd.cap_op = btmc_pkg::CAP_RATE;
            end
            STEP_TILT_CAP: cmd.cap_op = btmc_pkg::CAP_TILT;
            STEP_CORR:     cmd.mul_op = btmc_pkg::MUL_CORR;
            STEP_SUM:      cmd.cap_op = btmc_pkg::CAP_SUM;
            STEP_LO:       cmd.mul_op = btmc_pkg::MUL_STEP_LO;
            STEP_HI: begin
               cmd.mul_op = btmc_pkg::MUL_STEP_HI;
               cmd.cap_op = btmc_pkg::CAP_ACC_SET;
            end
            STEP_PD_ANGLE: begin
               cmd.mul_op = btmc_pkg::MUL_PD_ANGLE;
               cmd.cap_op = btmc_pkg::CAP_ACC_HI;
            end
            STEP_PD_RATE: begin
               cmd.mul_op = btmc_pkg::MUL_PD_RATE;
               cmd.cap_op = btmc_pkg::CAP_NEXT;
            end
            STEP_PD_ADD:   cmd.cap_op = btmc_pkg::CAP_ACC_ADD;
            STEP_WHEEL:    cmd.cap_op = btmc_pkg::CAP_WHEEL;
            default:       cmd.cap_op = btmc_pkg::CAP_NONE;
         endcase
      end
   end

   // Next state. A halted block skips the arithmetic and reports at once.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in  = STEP_RATE;
               state_in = status.halt ? ST_DONE : ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (step_ff == STEP_WHEEL) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_type'(step_ff + 4'd1);
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_RATE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### sv/btmc_datapath.sv
// ---------------------------------------------------------------------------
// Balance tilt motor controller datapath
// Shared multiplier, accumulator, angle integral, halt latch and result
// register.
// ---------------------------------------------------------------------------
module btmc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  btmc_pkg::cfg_type                 cfg,
   input  btmc_pkg::cmd_type                 cmd,
   input  logic [55:0]                       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [87:0]                       rsp_tdata,
   output logic [0:0]                        rsp_tuser,
   output btmc_pkg::status_type              status,
   output logic signed [btmc_pkg::AngleW-1:0] integral
);

   localparam int SampleW = btmc_pkg::SampleW;
   localparam int TermW   = btmc_pkg::TermW;
   localparam int DutyW   = btmc_pkg::DutyW;
   localparam int AngleW  = btmc_pkg::AngleW;
   localparam int DiffW   = btmc_pkg::DiffW;
   localparam int RateW   = btmc_pkg::RateW;
   localparam int MulAW   = btmc_pkg::MulAW;
   localparam int MulBW   = btmc_pkg::MulBW;
   localparam int ProdW   = btmc_pkg::ProdW;
   localparam int SumW    = btmc_pkg::SumW;
   localparam int SumLoW  = btmc_pkg::SumLoW;
   localparam int AccW    = btmc_pkg::AccW;
   localparam int WideW   = btmc_pkg::WideW;
   localparam int WheelW  = btmc_pkg::WheelW;

   // Latched input beat
   logic [SampleW-1:0]       accel_ff;
   logic [SampleW-1:0]       gyro_ff;
   logic signed [TermW-1:0]  speed_ff;
   logic signed [TermW-1:0]  steer_ff;

   // Working registers
   logic signed [ProdW-1:0]  prod_ff;
   logic signed [RateW-1:0]  rate_ff;
   logic signed [RateW-1:0]  tilt_ff;
   logic signed [SumW-1:0]   sum_ff;
   logic signed [AccW-1:0]   acc_ff;
   logic signed [AngleW-1:0] next_ff;
   logic signed [WheelW-1:0] left_ff;
   logic signed [WheelW-1:0] right_ff;

   // Control state
   logic signed [AngleW-1:0] integral_ff;
   logic                     halt_ff;
   logic                     out_valid_ff;

   // Result register
   logic [DutyW-1:0]         la_ff;
   logic [DutyW-1:0]         lb_ff;
   logic [DutyW-1:0]         ra_ff;
   logic [DutyW-1:0]         rb_ff;
   logic                     halted_ff;
   logic signed [AngleW-1:0] tilt_out_ff;

   // Combinational terms
   logic signed [DiffW-1:0]  gyro_diff;
   logic signed [DiffW-1:0]  accel_diff;
   logic signed [MulAW-1:0]  mul_a;
   logic signed [MulBW-1:0]  mul_b;
   logic signed [ProdW-1:0]  prod;
   logic signed [WideW-1:0]  next_sum;
   logic signed [AngleW-1:0] next_sat;
   logic signed [WideW-1:0]  pd;
   logic signed [WideW-1:0]  left_sum;
   logic signed [WideW-1:0]  right_sum;
   logic signed [WheelW-1:0] left_sat;
   logic signed [WheelW-1:0] right_sat;
   btmc_pkg::duty_pair_type  left_pair;
   btmc_pkg::duty_pair_type  right_pair;
   logic                     out_of_band;

   assign status.halt     = halt_ff;
   assign status.out_free = !out_valid_ff || rsp_tready;
   assign integral        = integral_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {tilt_out_ff, rb_ff, ra_ff, lb_ff, la_ff};
   assign rsp_tuser  = halted_ff;

   // Offsets minus samples; both stay within 13 signed bits.
   assign gyro_diff  = $signed({1'b0, cfg.gyro_bias}) - $signed({1'b0, gyro_ff});
   assign accel_diff = $signed({1'b0, cfg.accel_zero}) - $signed({1'b0, accel_ff});

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.mul_op)
         btmc_pkg::MUL_RATE: begin
            mul_a = MulAW'(gyro_diff);
            mul_b = btmc_pkg::RateScale;
         end
         btmc_pkg::MUL_TILT: begin
            mul_a = MulAW'(accel_diff);
            mul_b = btmc_pkg::TiltScale;
         end
         btmc_pkg::MUL_CORR: begin
            mul_a = MulAW'(tilt_ff) - MulAW'(integral_ff);
            mul_b = $signed({1'b0, cfg.inv_time_constant_q8});
         end
         btmc_pkg::MUL_STEP_LO: begin
            mul_a = $signed({{(MulAW-SumLoW){1'b0}}, sum_ff[SumLoW-1:0]});
            mul_b = $signed({1'b0, cfg.step_time_q16});
         end
         btmc_pkg::MUL_STEP_HI: begin
            // The upper slice carries the sign of the sum.
            mul_a = MulAW'($signed(sum_ff[SumW-1:SumLoW]));
            mul_b = $signed({1'b0, cfg.step_time_q16});
         end
         btmc_pkg::MUL_PD_ANGLE: begin
            mul_a = MulAW'(integral_ff);
            mul_b = $signed({1'b0, cfg.angle_gain});
         end
         btmc_pkg::MUL_PD_RATE: begin
            mul_a = MulAW'(rate_ff);
            mul_b = $signed({{(MulBW-10){1'b0}}, cfg.rate_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = ProdW'(mul_a) * ProdW'(mul_b);

   // Integral update, saturated to the signed 32-bit range.
   assign next_sum = WideW'(integral_ff) + WideW'(acc_ff >>> 16);
   always_comb begin
      if (next_sum > WideW'(32'sh7FFF_FFFF)) begin
         next_sat = 32'sh7FFF_FFFF;
      end else if (next_sum < -WideW'(64'sh8000_0000)) begin
         next_sat = 32'sh8000_0000;
      end else begin
         next_sat = next_sum[AngleW-1:0];
      end
   end

   // PD term plus speed and steering, saturated per wheel.
   assign pd        = WideW'(acc_ff >>> 16);
   assign left_sum  = pd + WideW'(speed_ff) + WideW'(steer_ff);
   assign right_sum = pd + WideW'(speed_ff) - WideW'(steer_ff);
   always_comb begin
      if (left_sum > btmc_pkg::DutyLimit) begin
         left_sat = WheelW'(btmc_pkg::DutyLimit);
      end else if (left_sum < -btmc_pkg::DutyLimit) begin
         left_sat = -WheelW'(btmc_pkg::DutyLimit);
      end else begin
         left_sat = left_sum[WheelW-1:0];
      end
      if (right_sum > btmc_pkg::DutyLimit) begin
         right_sat = WheelW'(btmc_pkg::DutyLimit);
      end else if (right_sum < -btmc_pkg::DutyLimit) begin
         right_sat = -WheelW'(btmc_pkg::DutyLimit);
      end else begin
         right_sat = right_sum[WheelW-1:0];
      end
   end

   // Bridge mapping and safe band check on the previous angle.
   assign left_pair   = btmc_pkg::bridge(left_ff, cfg.dead_left);
   assign right_pair  = btmc_pkg::bridge(right_ff, cfg.dead_right);
   assign out_of_band = (integral_ff > btmc_pkg::HaltHigh) ||
                        (integral_ff < btmc_pkg::HaltLow);

   // Payload registers: input latch, product and partial results.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         accel_ff <= req_tdata[11:0];
         gyro_ff  <= req_tdata[23:12];
         speed_ff <= $signed(req_tdata[39:24]);
         steer_ff <= $signed(req_tdata[55:40]);
      end
      prod_ff <= prod;
      case (cmd.cap_op)
         btmc_pkg::CAP_RATE:    rate_ff <= prod_ff[RateW-1:0];
         btmc_pkg::CAP_TILT:    tilt_ff <= prod_ff[RateW-1:0];
         btmc_pkg::CAP_SUM:     sum_ff  <= SumW'(rate_ff) + SumW'(prod_ff >>> 8);
         btmc_pkg::CAP_ACC_SET: acc_ff  <= AccW'(prod_ff);
         btmc_pkg::CAP_ACC_HI:  acc_ff  <= acc_ff + (AccW'(prod_ff) <<< SumLoW);
         btmc_pkg::CAP_NEXT: begin
            next_ff <= next_sat;
            acc_ff  <= AccW'(prod_ff);
         end
         btmc_pkg::CAP_ACC_ADD: acc_ff  <= acc_ff + AccW'(prod_ff);
         btmc_pkg::CAP_WHEEL: begin
            left_ff  <= left_sat;
            right_ff <= right_sat;
         end
         default: acc_ff <= acc_ff;
      endcase
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         tilt_out_ff <= integral_ff;
         if (halt_ff || out_of_band) begin
            la_ff     <= btmc_pkg::DutyFull;
            lb_ff     <= btmc_pkg::DutyFull;
            ra_ff     <= btmc_pkg::DutyFull;
            rb_ff     <= btmc_pkg::DutyFull;
            halted_ff <= 1'b1;
         end else begin
            la_ff     <= left_pair.a;
            lb_ff     <= left_pair.b;
            ra_ff     <= right_pair.a;
            rb_ff     <= right_pair.b;
            halted_ff <= 1'b0;
         end
      end
   end

   // Angle integral, halt latch and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff  <= '0;
         halt_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish && !halt_ff) begin
            integral_ff <= next_ff;
            halt_ff     <= out_of_band;
         end
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### sv/balance_tilt_motor_controller.sv
// ---------------------------------------------------------------------------
// Balance tilt motor controller
// Complementary filter angle estimate and PD balance loop driving two
// H-bridge pairs, one control tick per request beat.
// ---------------------------------------------------------------------------
//
// Channel  Direction  Payload
// req      in         tdata: accel_sample, gyro_sample, speed_term, steer_term
// rsp      out        tdata: four duties and tilt_estimate; tuser: halted
// csr      in         csr_index selects one of eight registers, csr_data value
//
// A tick runs from the request beat to the response: eleven steps through
// the one shared 33x17 multiplier and its accumulator, then the load of the
// response register. Once halted, a tick skips the steps.
// A new request beat is taken as soon as the response is loaded, while that
// response still waits for rsp_tready; a stalled response holds the next
// tick in its done state. Synchronous reset clears the angle integral, the
// halt latch and the registers to their defaults. CSR writes are never stalled.
//
module balance_tilt_motor_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // accel_sample, gyro_sample, speed_term, steer_term
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // duty_left_a, duty_left_b, duty_right_a,
                                    // duty_right_b, tilt_estimate
   output logic [0:0]  rsp_tuser,   // halted
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   btmc_pkg::cfg_type                  cfg;
   btmc_pkg::cmd_type                  cmd;
   btmc_pkg::status_type               status;
   logic signed [btmc_pkg::AngleW-1:0] integral;

   btmc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   btmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   btmc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (status),
      .integral   (integral)
   );

   // The halt latch is only cleared by reset.
   assert property (@(posedge clock) disable iff (reset)
      status.halt |=> status.halt)
      else $error("halt latch cleared without reset");

   // While halted the angle integral is frozen.
   assert property (@(posedge clock) disable iff (reset)
      status.halt |=> $stable(integral))
      else $error("angle integral moved while halted");

   // A halted response drives all four duties full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[13:0] == btmc_pkg::DutyFull && rsp_tdata[27:14] == btmc_pkg::DutyFull &&
         rsp_tdata[41:28] == btmc_pkg::DutyFull && rsp_tdata[55:42] == btmc_pkg::DutyFull)
      else $error("halted response with a reduced duty");

   // In normal running each bridge has its driving side at full duty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         (rsp_tdata[13:0] == btmc_pkg::DutyFull || rsp_tdata[27:14] == btmc_pkg::DutyFull) &&
         (rsp_tdata[41:28] == btmc_pkg::DutyFull || rsp_tdata[55:42] == btmc_pkg::DutyFull))
      else $error("bridge pair without a full duty side");

endmodule
